FILE: design/slot_pool_allocator_macros.svh
// ----------------------------------------------------------------------------
// slot_pool_allocator assertion macros
// Shared concurrent assertion forms for the slot pool allocator.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_ALLOCATOR_MACROS_SVH
`define SLOT_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Constants, codes and types of the slot pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int COUNT_W    = 7;
  localparam int BYTES_W    = 16;
  localparam int OFFSET_W   = 22;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LINK_W-1:0]  NIL_LINK    = LINK_W'(SLOTS);
  localparam logic [COUNT_W-1:0] POOL_MAX    = COUNT_W'(SLOTS);
  localparam logic [COUNT_W-1:0] POOL_RESET  = (SLOTS < 64) ? COUNT_W'(SLOTS) : COUNT_W'(64);
  localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(64);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_SLOTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 1'b1;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [LINK_W-1:0]   link_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [STATUS_W-1:0] status_t;

  typedef struct packed {
    logic accept;
    logic link_phase;
    logic finish;
  } spa_cmd_t;

  typedef struct packed {
    logic reject;
  } spa_sts_t;

endpackage

`default_nettype wire

FILE: design/spa_req_if.sv
// ----------------------------------------------------------------------------
// spa_req_if
// Request channel: allocate or release beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_req_if;
  import spa_pkg::*;

  logic  valid;
  logic  ready;
  logic  mode;
  slot_t slot_index;

  modport source (output valid, output mode, output slot_index, input ready);
  modport sink   (input valid, input mode, input slot_index, output ready);
endinterface

`default_nettype wire

FILE: design/spa_rsp_if.sv
// ----------------------------------------------------------------------------
// spa_rsp_if
// Response channel: one result beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_rsp_if;
  import spa_pkg::*;

  logic                  valid;
  logic                  ready;
  status_t               status;
  slot_t                 granted_slot;
  logic [OFFSET_W-1:0]   byte_offset;
  count_t                free_count;
  count_t                used_count;

  modport source (output valid, output status, output granted_slot, output byte_offset,
                  output free_count, output used_count, input ready);
  modport sink   (input valid, input status, input granted_slot, input byte_offset,
                  input free_count, input used_count, output ready);
endinterface

`default_nettype wire

FILE: design/spa_ram.sv
// ----------------------------------------------------------------------------
// spa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl
// Request sequencer: accept, link update, finish and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      spa_pkg::spa_cmd_t cmd,
  input  wire spa_pkg::spa_sts_t sts
);
  import spa_pkg::*;

  localparam logic [1:0] IDLE = 2'd0;
  localparam logic [1:0] READ = 2'd1;
  localparam logic [1:0] FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready       = (state == IDLE);
  assign out_free       = !out_valid || out_ready;
  assign cmd.accept     = in_valid && in_ready;
  assign cmd.link_phase = (state == READ);
  assign cmd.finish     = (state == FIN) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (cmd.accept) begin
          state_next = sts.reject ? FIN : READ;
        end
      end
      READ: begin
        state_next = FIN;
      end
      FIN: begin
        if (out_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/spa_dp.sv
// ----------------------------------------------------------------------------
// spa_dp
// Link tables, list heads, counters, offset multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire spa_pkg::spa_cmd_t                cmd,
  output      spa_pkg::spa_sts_t                sts,
  input  wire logic                             in_mode,
  input  wire spa_pkg::slot_t                   in_slot,
  input  wire logic                             cfg_we,
  input  wire logic [spa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spa_pkg::CFG_DATA_W-1:0]   cfg_data,
  output      spa_pkg::status_t                 out_status,
  output      spa_pkg::slot_t                   out_slot,
  output      logic [spa_pkg::OFFSET_W-1:0]     out_offset,
  output      spa_pkg::count_t                  out_free_count,
  output      spa_pkg::count_t                  out_used_count
);
  import spa_pkg::*;

  function automatic count_t clamp_pool(input logic [CFG_DATA_W-1:0] value);
    count_t v;
    v = value[COUNT_W-1:0];
    if (v == '0) begin
      v = COUNT_W'(1);
    end
    if (v > POOL_MAX) begin
      v = POOL_MAX;
    end
    return v;
  endfunction

  count_t               pool_slots;
  logic [BYTES_W-1:0]   slot_bytes;
  link_t                free_head;
  link_t                used_head;
  count_t               free_total;
  count_t               used_total;
  logic [SLOTS-1:0]     in_use;
  logic [SLOTS-1:0]     next_vld;

  logic                 op_mode;
  logic                 op_ok;
  status_t              op_status;
  slot_t                cur_slot;
  link_t                link_p;
  link_t                link_n;
  logic [OFFSET_W-1:0]  prod;

  logic                 alloc_empty;
  logic                 bad_free;
  slot_t                acc_slot;
  link_t                succ;
  link_t                next_dflt;
  link_t                n_val;
  count_t               free_total_next;
  count_t               used_total_next;
  count_t               pool_new;
  logic [SLOT_W+BYTES_W-1:0] mul;

  logic                 nx_we;
  slot_t                nx_waddr;
  link_t                nx_wdata;
  link_t                nx_rdata;
  logic                 pv_we;
  slot_t                pv_waddr;
  link_t                pv_wdata;
  link_t                pv_rdata;

  // accept-time checks
  assign alloc_empty = (free_total == '0) || (free_head == NIL_LINK);
  assign bad_free    = (COUNT_W'(in_slot) >= pool_slots) || !in_use[in_slot];
  assign sts.reject  = (in_mode == MODE_ALLOC) ? alloc_empty : bad_free;
  assign acc_slot    = (in_mode == MODE_ALLOC) ? free_head[SLOT_W-1:0] : in_slot;

  // untouched free entries chain to their successor
  assign succ      = LINK_W'(cur_slot) + LINK_W'(1);
  assign next_dflt = (succ < LINK_W'(pool_slots)) ? succ : NIL_LINK;
  assign n_val     = next_vld[cur_slot] ? nx_rdata : next_dflt;

  assign mul      = (SLOT_W+BYTES_W)'(cur_slot) * (SLOT_W+BYTES_W)'(slot_bytes);
  assign pool_new = clamp_pool(cfg_data);

  assign free_total_next = (op_mode == MODE_ALLOC) ? free_total - COUNT_W'(1)
                                                   : free_total + COUNT_W'(1);
  assign used_total_next = (op_mode == MODE_ALLOC) ? used_total + COUNT_W'(1)
                                                   : used_total - COUNT_W'(1);

  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = cur_slot;
    nx_wdata = used_head;
    pv_we    = 1'b0;
    pv_waddr = cur_slot;
    pv_wdata = NIL_LINK;
    if (cmd.link_phase) begin
      nx_we = 1'b1;
      if (op_mode == MODE_ALLOC) begin
        nx_wdata = used_head;
        pv_we    = 1'b1;
      end else begin
        nx_wdata = free_head;
        pv_we    = (n_val != NIL_LINK);
        pv_waddr = n_val[SLOT_W-1:0];
        pv_wdata = pv_rdata;
      end
    end else if (cmd.finish && op_ok) begin
      if (op_mode == MODE_ALLOC) begin
        pv_we    = (used_head != NIL_LINK);
        pv_waddr = used_head[SLOT_W-1:0];
        pv_wdata = LINK_W'(cur_slot);
      end else begin
        nx_we    = (link_p != NIL_LINK);
        nx_waddr = link_p[SLOT_W-1:0];
        nx_wdata = link_n;
      end
    end
  end

  spa_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (acc_slot),
    .rdata (nx_rdata)
  );

  spa_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (acc_slot),
    .rdata (pv_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_mode   <= in_mode;
      op_ok     <= !sts.reject;
      cur_slot  <= acc_slot;
      op_status <= !sts.reject ? ST_OK : ((in_mode == MODE_ALLOC) ? ST_EMPTY : ST_BAD);
    end
    if (cmd.link_phase) begin
      prod   <= mul[OFFSET_W-1:0];
      link_p <= pv_rdata;
      link_n <= n_val;
    end
    if (cmd.finish) begin
      out_status     <= op_status;
      out_slot       <= op_ok ? cur_slot : '0;
      out_offset     <= op_ok ? prod : '0;
      out_free_count <= op_ok ? free_total_next : free_total;
      out_used_count <= op_ok ? used_total_next : used_total;
    end
  end

  // list state
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_slots <= POOL_RESET;
      slot_bytes <= BYTES_RESET;
      free_head  <= '0;
      used_head  <= NIL_LINK;
      free_total <= POOL_RESET;
      used_total <= '0;
      in_use     <= '0;
      next_vld   <= '0;
    end else begin
      if (cmd.link_phase) begin
        next_vld[cur_slot] <= 1'b1;
        if (op_mode == MODE_ALLOC) begin
          in_use[cur_slot] <= 1'b1;
          free_head        <= n_val;
        end else begin
          in_use[cur_slot] <= 1'b0;
          free_head        <= LINK_W'(cur_slot);
        end
      end
      if (cmd.finish && op_ok) begin
        free_total <= free_total_next;
        used_total <= used_total_next;
        if (op_mode == MODE_ALLOC) begin
          used_head <= LINK_W'(cur_slot);
        end else if (link_p == NIL_LINK) begin
          used_head <= link_n;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POOL_SLOTS: begin
            pool_slots <= pool_new;
            free_head  <= '0;
            used_head  <= NIL_LINK;
            free_total <= pool_new;
            used_total <= '0;
            in_use     <= '0;
            next_vld   <= '0;
          end
          REG_SLOT_BYTES: begin
            slot_bytes <= cfg_data[BYTES_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator
// Fixed pool of equal-size slots kept as free and allocated linked lists.
//
//   channel  dir  beat contents
//   req      in   mode, slot_index
//   rsp      out  status, granted_slot, byte_offset, free_count, used_count
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A successful request passes through accept with link table read, link update
// and finish, and its beat is registered onto rsp at finish; a refused one
// skips the link update and goes from accept straight to finish.
// Each link table is a RAM with one write port, which sets the two update steps.
// Reset and a pool_slots write rebuild the lists at once through per-slot valid bits.
// A result waiting on rsp holds the finish step, and req stays low until it moves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "slot_pool_allocator_macros.svh"

module slot_pool_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  spa_req_if.sink                             req,
  spa_rsp_if.source                           rsp,
  input  wire logic                           cfg_we,
  input  wire logic [spa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [spa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spa_pkg::*;

  spa_cmd_t cmd;
  spa_sts_t sts;

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  spa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (req.mode),
    .in_slot        (req.slot_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_status     (rsp.status),
    .out_slot       (rsp.granted_slot),
    .out_offset     (rsp.byte_offset),
    .out_free_count (rsp.free_count),
    .out_used_count (rsp.used_count)
  );

  `SPA_ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready, "request taken while busy")
  `SPA_ASSERT_IMPL(a_refusal_zeroed, clk, rst, rsp.valid && (rsp.status != ST_OK), (rsp.granted_slot == '0) && (rsp.byte_offset == '0), "refused beat carries a slot")
  `SPA_ASSERT_IMPL(a_empty_count, clk, rst, rsp.valid && (rsp.status == ST_EMPTY), rsp.free_count == '0, "empty reported with free slots")
  `SPA_ASSERT_IMPL(a_count_sum, clk, rst, rsp.valid, ((COUNT_W+1)'(rsp.free_count) + (COUNT_W+1)'(rsp.used_count)) <= (COUNT_W+1)'(SLOTS), "counts exceed pool")

endmodule

`default_nettype wire

FILE: test/slot_pool_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_checker
// Watches the request, response and register ports of the slot pool
// allocator. Keeps its own copy of the free and allocated lists, works out
// the result of every accepted request and compares it field by field with
// the response beats in order.
// ----------------------------------------------------------------------------
module slot_pool_allocator_checker
  import spa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  spa_req_if                    req,
  spa_rsp_if                    rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fails,
  output int                    pending,
  output int                    ok_beats,
  output int                    empty_beats,
  output int                    bad_beats
);

  typedef struct packed {
    status_t             status;
    slot_t               slot;
    logic [OFFSET_W-1:0] offset;
    count_t              free_cnt;
    count_t              used_cnt;
  } pool_result_t;

  count_t              pool_slots;
  logic [BYTES_W-1:0]  slot_bytes;
  link_t               next_link [SLOTS];
  link_t               prev_link [SLOTS];
  bit                  in_use    [SLOTS];
  link_t               free_head;
  link_t               used_head;
  count_t              free_total;
  count_t              used_total;

  pool_result_t        awaited_results [$];
  int                  fail_cnt;
  int                  ok_cnt;
  int                  empty_cnt;
  int                  bad_cnt;

  initial begin
    fail_cnt  = 0;
    ok_cnt    = 0;
    empty_cnt = 0;
    bad_cnt   = 0;
  end

  function automatic void rebuild_pool();
    for (int i = 0; i < SLOTS; i++) begin
      next_link[i] = NIL_LINK;
      prev_link[i] = NIL_LINK;
      in_use[i]    = 1'b0;
    end
    for (int i = 0; i < int'(pool_slots); i++) begin
      next_link[i] = (i + 1 < int'(pool_slots)) ? link_t'(i + 1) : NIL_LINK;
      prev_link[i] = (i == 0) ? NIL_LINK : link_t'(i - 1);
    end
    free_head  = '0;
    used_head  = NIL_LINK;
    free_total = pool_slots;
    used_total = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    count_t v;
    if (idx == REG_POOL_SLOTS) begin
      v = data[COUNT_W-1:0];
      if (v == '0) v = count_t'(1);
      if (v > POOL_MAX) v = POOL_MAX;
      pool_slots = v;
      rebuild_pool();
    end else begin
      slot_bytes = data[BYTES_W-1:0];
    end
  endfunction

  function automatic pool_result_t pool_step(input logic m, input slot_t s);
    pool_result_t r;
    link_t        slot_l;
    link_t        p;
    link_t        n;
    r        = '0;
    r.status = ST_OK;
    if (m == MODE_ALLOC) begin
      if (free_total == '0 || free_head >= NIL_LINK) begin
        r.status = ST_EMPTY;
      end else begin
        slot_l    = free_head;
        free_head = next_link[slot_l];
        if (free_head < NIL_LINK) prev_link[free_head] = NIL_LINK;
        prev_link[slot_l] = NIL_LINK;
        next_link[slot_l] = used_head;
        if (used_head < NIL_LINK) prev_link[used_head] = slot_l;
        used_head      = slot_l;
        in_use[slot_l] = 1'b1;
        used_total++;
        free_total--;
        r.slot = slot_l[SLOT_W-1:0];
      end
    end else begin
      slot_l = link_t'(s);
      if (slot_l >= link_t'(pool_slots) || !in_use[slot_l]) begin
        r.status = ST_BAD;
      end else begin
        p = prev_link[slot_l];
        n = next_link[slot_l];
        if (p < NIL_LINK) next_link[p] = n;
        else used_head = n;
        if (n < NIL_LINK) prev_link[n] = p;
        next_link[slot_l] = free_head;
        prev_link[slot_l] = NIL_LINK;
        if (free_head < NIL_LINK) prev_link[free_head] = slot_l;
        free_head      = slot_l;
        in_use[slot_l] = 1'b0;
        used_total--;
        free_total++;
        r.slot = s;
      end
    end
    if (r.status == ST_OK) r.offset = OFFSET_W'(r.slot) * OFFSET_W'(slot_bytes);
    r.free_cnt = free_total;
    r.used_cnt = used_total;
    return r;
  endfunction

  function automatic void check_beat();
    pool_result_t want;
    if (awaited_results.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("[%0t] response beat with nothing awaited: status %0d slot %0d", $time,
                 rsp.status, rsp.granted_slot);
      return;
    end
    want = awaited_results.pop_front();
    case (want.status)
      ST_OK:    ok_cnt++;
      ST_EMPTY: empty_cnt++;
      default:  bad_cnt++;
    endcase
    if (rsp.status !== want.status || rsp.granted_slot !== want.slot ||
        rsp.byte_offset !== want.offset || rsp.free_count !== want.free_cnt ||
        rsp.used_count !== want.used_cnt) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("[%0t] mismatch: expected status %0d slot %0d offset %0d free %0d used %0d",
                 $time, want.status, want.slot, want.offset, want.free_cnt, want.used_cnt);
        $display("[%0t]           actual   status %0d slot %0d offset %0d free %0d used %0d",
                 $time, rsp.status, rsp.granted_slot, rsp.byte_offset, rsp.free_count,
                 rsp.used_count);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pool_slots = POOL_RESET;
      slot_bytes = BYTES_RESET;
      rebuild_pool();
      awaited_results.delete();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) check_beat();
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (req.valid === 1'b1 && req.ready === 1'b1)
        awaited_results.push_back(pool_step(req.mode, req.slot_index));
    end
    fails       <= fail_cnt;
    pending     <= awaited_results.size();
    ok_beats    <= ok_cnt;
    empty_beats <= empty_cnt;
    bad_beats   <= bad_cnt;
  end

endmodule

FILE: test/slot_pool_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_test
// Drives allocate and release beats into the slot pool allocator under
// several pool sizes and slot sizes, with random stalls on both channels,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module slot_pool_allocator_test;
  import spa_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fails;
  int pending;
  int ok_beats;
  int empty_beats;
  int bad_beats;
  int beats_sent;
  int reg_writes;
  int pool_n;
  bit quiet;

  spa_req_if req_ch ();
  spa_rsp_if rsp_ch ();

  slot_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  slot_pool_allocator_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .pending     (pending),
    .ok_beats    (ok_beats),
    .empty_beats (empty_beats),
    .bad_beats   (bad_beats)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = idle_len();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_beat(input logic m, input slot_t s);
    int gap;
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= m;
    req_ch.slot_index <= s;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    beats_sent++;
    gap = idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_pool();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int v;
    settle_pool();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (idx == REG_POOL_SLOTS) begin
      v = int'(data[COUNT_W-1:0]);
      if (v == 0) v = 1;
      if (v > SLOTS) v = SLOTS;
      pool_n = v;
    end
  endtask

  task automatic alloc_beat();
    send_beat(MODE_ALLOC, slot_t'($urandom));
  endtask

  initial begin
    int alloc_pct;
    int pause_at;
    logic [CFG_DATA_W-1:0] pool_data;
    logic [CFG_DATA_W-1:0] bytes_data;
    slot_t idx;

    beats_sent        = 0;
    reg_writes        = 0;
    pool_n            = int'(POOL_RESET);
    quiet             = 1'b0;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_POOL_SLOTS;
    cfg_data         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_ALLOC;
    req_ch.slot_index <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // release of a free slot, list unlinking at middle, head and tail
    send_beat(MODE_FREE, slot_t'(0));
    repeat (3) alloc_beat();
    send_beat(MODE_FREE, slot_t'(1));
    send_beat(MODE_FREE, slot_t'(2));
    send_beat(MODE_FREE, slot_t'(0));
    send_beat(MODE_FREE, slot_t'(0));

    write_reg(REG_SLOT_BYTES, 16'hFFFF);
    repeat (2) alloc_beat();

    // slot count of zero taken as one: empty pool and out of range releases
    write_reg(REG_POOL_SLOTS, 16'd0);
    repeat (2) alloc_beat();
    send_beat(MODE_FREE, slot_t'(1));
    send_beat(MODE_FREE, slot_t'(63));
    send_beat(MODE_FREE, slot_t'(0));

    // oversized slot count clamped, zero slot size
    write_reg(REG_POOL_SLOTS, 16'd200);
    write_reg(REG_SLOT_BYTES, 16'd0);
    repeat (2) alloc_beat();
    send_beat(MODE_FREE, slot_t'(1));
    write_reg(REG_POOL_SLOTS, 16'h007F);
    alloc_beat();
    send_beat(MODE_FREE, slot_t'(63));

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       begin pool_data = 16'd1;    bytes_data = 16'hFFFF; alloc_pct = 50; end
        1:       begin pool_data = 16'd2;    bytes_data = 16'd0;    alloc_pct = 55; end
        2:       begin pool_data = 16'hFFFF; bytes_data = 16'd1;    alloc_pct = 90; end
        3:       begin pool_data = 16'd64;   bytes_data = 16'hFFFF; alloc_pct = 75; end
        default: begin
          if ($urandom_range(0, 3) == 0) pool_data = 16'($urandom);
          else pool_data = 16'($urandom_range(1, 64));
          case ($urandom_range(0, 3))
            0:       bytes_data = 16'hFFFF;
            1:       bytes_data = 16'd64;
            default: bytes_data = 16'($urandom);
          endcase
          alloc_pct = $urandom_range(35, 80);
        end
      endcase
      write_reg(REG_POOL_SLOTS, pool_data);
      write_reg(REG_SLOT_BYTES, bytes_data);
      quiet    = (ph % 4 == 3);
      pause_at = $urandom_range(20, 100);
      for (int k = 0; k < 119; k++) begin
        if (k == pause_at) settle_pool();
        if ($urandom_range(0, 99) < alloc_pct) begin
          alloc_beat();
        end else begin
          if ($urandom_range(0, 9) == 0) idx = slot_t'($urandom);
          else idx = slot_t'($urandom_range(0, pool_n - 1));
          send_beat(MODE_FREE, idx);
        end
      end
    end

    quiet = 1'b0;
    settle_pool();
    repeat (8) @(posedge clk);

    $display("covered %0d request beats over %0d register writes", beats_sent, reg_writes);
    $display("results: %0d granted or released, %0d pool empty, %0d refused releases",
             ok_beats, empty_beats, bad_beats);
    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
